// ----- design/ffc_pkg.sv -----
// Package for the flat-field correction block: request kinds, status codes,
// register indexes, fixed-point constants and the pipeline side-band type.
// It has no dependencies; the top module, ffc_addr and ffc_scale import it.
package ffc_pkg;

  // Kind of an input request, carried in tuser.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CORR  = 2'd1,
    REQ_START = 2'd2
  } req_e;

  // Status reported with every result.
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FLAT_WIDTH  = 2'd0,
    CFG_FLAT_HEIGHT = 2'd1,
    CFG_LUT_WIDTH   = 2'd2,
    CFG_LUT_HEIGHT  = 2'd3
  } cfg_idx_e;

  localparam int unsigned SIZE_W     = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Unsigned Q4.12 scaling with rounding by just under one half.
  localparam int unsigned Q_SHIFT    = 12;
  localparam int unsigned ROUND_ADD  = 2047;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned SCALED_W   = 13;
  localparam int unsigned FRAC_LIMIT = 256;
  localparam logic [7:0]  FRAC_SAT   = 8'd255;

  // Target decode of one request.
  typedef struct packed {
    logic hit;       // correction target lies inside the table and store
    logic load_ok;   // load position lies inside the store
    logic mismatch;  // flat and table sizes differ
  } tgt_t;

  // Side-band that travels with a request down the pipeline.
  typedef struct packed {
    req_e       req;
    logic       use_mem;   // fraction is scaled by a stored flat value
    logic       mismatch;
    logic [7:0] frac;
  } info_t;

endpackage

// ----- design/flat_field_lut_correction.sv -----
// Flat-field correction of distortion rebin fractions. The block takes one
// request per clock cycle while the result stream does not stall, and returns
// one result per request after the flat-store read stage, the 8x16 multiply
// stage and the rounding stage into the output register. The sustained
// rate of one request per cycle is set by the single store port, which takes
// either the write of a load or the read of a correction in each cycle. A
// load written in one cycle is seen by a correction accepted in the next.
// The store comes out of reset unwritten and has no clearing pass; every
// entry must be loaded before a correction reads it.
// Depends on ffc_pkg, ffc_ram, ffc_addr and ffc_scale.
module flat_field_lut_correction #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [ffc_pkg::SIZE_W-1:0] cfg_data_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pix_x[7:0], pix_y[15:8], shift_x[23:16], shift_y[31:24], sub_col[33:32],
  // sub_row[35:34], fraction[43:36], flat_value[59:44], zero fill[63:60]
  input  logic [63:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_frac[7:0], clipped[8], status[10:9], zero fill[15:11]
  output logic [15:0] m_axis_tdata
);
  import ffc_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [SIZE_W-1:0] flat_width_q, flat_height_q, lut_width_q, lut_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_width_q  <= SIZE_RESET;
      flat_height_q <= SIZE_RESET;
      lut_width_q   <= SIZE_RESET;
      lut_height_q  <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FLAT_WIDTH:  flat_width_q  <= cfg_data_i;
        CFG_FLAT_HEIGHT: flat_height_q <= cfg_data_i;
        CFG_LUT_WIDTH:   lut_width_q   <= cfg_data_i;
        CFG_LUT_HEIGHT:  lut_height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request fields.
  logic [7:0]  in_frac;
  logic [15:0] in_flat;
  req_e        in_req;

  assign in_frac = s_axis_tdata[43:36];
  assign in_flat = s_axis_tdata[59:44];
  assign in_req  = req_e'(s_axis_tuser);

  // Target decode of the incoming request.
  logic [AW-1:0] rd_addr, wr_addr;
  tgt_t          tgt;

  ffc_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_addr (
    .pix_x_i       (s_axis_tdata[7:0]),
    .pix_y_i       (s_axis_tdata[15:8]),
    .shift_x_i     (s_axis_tdata[23:16]),
    .shift_y_i     (s_axis_tdata[31:24]),
    .sub_col_i     (s_axis_tdata[33:32]),
    .sub_row_i     (s_axis_tdata[35:34]),
    .flat_width_i  (flat_width_q),
    .flat_height_i (flat_height_q),
    .lut_width_i   (lut_width_q),
    .lut_height_i  (lut_height_q),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .tgt_o         (tgt)
  );

  // Per-stage advance: a stage loads when it is empty or its content moves on.
  logic v1_q, v2_q, vo_q;
  logic en_o, en2, en1, accept;

  assign en_o          = !vo_q || m_axis_tready;
  assign en2           = !v2_q || en_o;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept        = s_axis_tvalid && en1;

  info_t info0;
  assign info0.req      = in_req;
  assign info0.mismatch = tgt.mismatch;
  assign info0.frac     = in_frac;
  assign info0.use_mem  = (in_req == REQ_CORR) && !tgt.mismatch && (in_frac != 8'd0)
                          && tgt.hit;

  // Flat store: a load writes, a correction that needs a flat value reads.
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_addr;
  logic [15:0]    ram_rdata;

  assign ram_we   = accept && (in_req == REQ_LOAD) && tgt.load_ok;
  assign ram_re   = accept && info0.use_mem;
  assign ram_addr = ram_we ? wr_addr : rd_addr;

  ffc_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_flat),
    .rdata_o (ram_rdata)
  );

  // Stage 1: waits for the store read.
  info_t info1_q, info2_q;
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) info1_q <= info0;
  end

  // Stage 2: fraction times flat value.
  always_ff @(posedge clk_i) begin
    if (en2) begin
      info2_q <= info1_q;
      prod_q  <= PROD_W'(info1_q.frac) * PROD_W'(ram_rdata);
    end
  end

  // Stage 3: round, saturate, update the overflow flag and form the status.
  logic [7:0] scaled;
  logic       scale_clip;

  ffc_scale u_scale (
    .prod_i  (prod_q),
    .value_o (scaled),
    .clip_o  (scale_clip)
  );

  logic       ovf_q, ovf_d;
  logic [7:0] res_d, res_q;
  logic       clip_d, clip_q;
  status_e    status_d, status_q;

  always_comb begin
    res_d  = 8'd0;
    clip_d = 1'b0;
    ovf_d  = ovf_q;
    case (info2_q.req)
      REQ_CORR: begin
        if (info2_q.use_mem) begin
          res_d  = scaled;
          clip_d = scale_clip;
          if (scale_clip) ovf_d = 1'b1;
        end else begin
          res_d = info2_q.frac;
        end
      end
      REQ_START: ovf_d = 1'b0;
      default: ;
    endcase
    if (info2_q.mismatch) begin
      status_d = ST_MISMATCH;
    end else if (ovf_d) begin
      status_d = ST_OVERFLOW;
    end else begin
      status_d = ST_GOOD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q  <= 1'b0;
      ovf_q <= 1'b0;
    end else if (en_o) begin
      vo_q <= v2_q;
      if (v2_q) ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v2_q) begin
      res_q    <= res_d;
      clip_q   <= clip_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {5'd0, status_q, clip_q, res_q};

endmodule

// ----- design/ffc_ram.sv -----
// Generic single-port RAM with one write or read address per cycle and a
// registered read port. No dependencies.
module ffc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; the read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ffc_addr.sv -----
// Target decode: shifted pixel position, bounds checks and store addresses.
// Depends on ffc_pkg.
module ffc_addr #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned AW         = 16
) (
  input  logic [7:0]                 pix_x_i,
  input  logic [7:0]                 pix_y_i,
  input  logic [7:0]                 shift_x_i,
  input  logic [7:0]                 shift_y_i,
  input  logic [1:0]                 sub_col_i,
  input  logic [1:0]                 sub_row_i,
  input  logic [ffc_pkg::SIZE_W-1:0] flat_width_i,
  input  logic [ffc_pkg::SIZE_W-1:0] flat_height_i,
  input  logic [ffc_pkg::SIZE_W-1:0] lut_width_i,
  input  logic [ffc_pkg::SIZE_W-1:0] lut_height_i,
  output logic [AW-1:0]              rd_addr_o,
  output logic [AW-1:0]              wr_addr_o,
  output ffc_pkg::tgt_t              tgt_o
);
  import ffc_pkg::*;

  logic signed [10:0] tx;
  logic signed [10:0] ty;
  logic               x_in;
  logic               y_in;

  // Target position: pixel plus signed shift plus sub-position.
  assign tx = $signed({3'b000, pix_x_i}) + $signed({{3{shift_x_i[7]}}, shift_x_i})
            + $signed({9'd0, sub_col_i});
  assign ty = $signed({3'b000, pix_y_i}) + $signed({{3{shift_y_i[7]}}, shift_y_i})
            + $signed({9'd0, sub_row_i});

  // The target must be non-negative and below both the table and store bounds.
  assign x_in = !tx[10] && (tx[9:0] < {1'b0, lut_width_i}) && (int'(tx) < MAX_WIDTH);
  assign y_in = !ty[10] && (ty[9:0] < {1'b0, lut_height_i}) && (int'(ty) < MAX_HEIGHT);

  // Row-major store addresses.
  assign rd_addr_o = AW'(ty[9:0]) * AW'(MAX_WIDTH) + AW'(tx[9:0]);
  assign wr_addr_o = AW'(pix_y_i) * AW'(MAX_WIDTH) + AW'(pix_x_i);

  assign tgt_o.hit      = x_in && y_in;
  assign tgt_o.load_ok  = (32'(pix_x_i) < MAX_WIDTH) && (32'(pix_y_i) < MAX_HEIGHT);
  assign tgt_o.mismatch = (flat_width_i != lut_width_i) || (flat_height_i != lut_height_i);

endmodule

// ----- design/ffc_scale.sv -----
// Rounding and saturation of a fraction times flat product in Q.12.
// Depends on ffc_pkg.
module ffc_scale (
  input  logic [ffc_pkg::PROD_W-1:0] prod_i,
  output logic [7:0]                 value_o,
  output logic                       clip_o
);
  import ffc_pkg::*;

  logic [PROD_W:0]     sum;
  logic [SCALED_W-1:0] scaled;

  // Add just under one half, then drop the fraction bits.
  assign sum    = {1'b0, prod_i} + (PROD_W + 1)'(ROUND_ADD);
  assign scaled = SCALED_W'(sum >> Q_SHIFT);

  // Values of 256 or more saturate.
  assign clip_o  = (32'(scaled) >= FRAC_LIMIT);
  assign value_o = clip_o ? FRAC_SAT : scaled[7:0];

endmodule
